// ===== rtl/mwt_pkg.sv =====
`default_nettype none

package mwt_pkg;

   localparam int LANES       = 5;
   localparam int MEDIAN_RANK = 2;
   localparam int RANK_W      = 3;

   localparam int DEAD_W  = 12;
   localparam int HOLD_W  = 32;
   localparam int TIME_W  = 48;
   localparam int TURN_W  = 32;
   localparam int DIR_W   = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [DEAD_W-1:0] DEAD_MAX_RESET       = 12'd80;
   localparam logic [DEAD_W-1:0] WRAP_MIN_DELTA_RESET = 12'd300;
   localparam logic [HOLD_W-1:0] MOTION_HOLD_RESET    = 32'd1000000;
   localparam logic [TURN_W-1:0] TURN_SCALE           = 32'd1000;

   // direction codes, any code with the top bit set counts as reverse
   localparam logic [DIR_W-1:0] DIR_NONE    = 2'b00;
   localparam logic [DIR_W-1:0] DIR_FORWARD = 2'b01;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DEAD_MAX       = 2'd0,
      CSR_WRAP_MIN_DELTA = 2'd1,
      CSR_MOTION_HOLD_US = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [DEAD_W-1:0] dead_max;
      logic [DEAD_W-1:0] wrap_min_delta;
      logic [HOLD_W-1:0] motion_hold_us;
   } cfg_type;

endpackage

`default_nettype wire

// ===== rtl/mwt_if.sv =====
`default_nettype none

interface mwt_req_if #(
   parameter int ADC_BITS = 12
);
   logic                valid;
   logic                ready;
   logic [ADC_BITS-1:0] sample_0;
   logic [ADC_BITS-1:0] sample_1;
   logic [ADC_BITS-1:0] sample_2;
   logic [ADC_BITS-1:0] sample_3;
   logic [ADC_BITS-1:0] sample_4;
   logic [4:0]          sample_fail_mask;
   logic signed [1:0]   requested_dir;
   logic signed [1:0]   drive_dir;
   logic                zero_request;
   logic [47:0]         time_us;

   modport source (
      output valid, sample_0, sample_1, sample_2, sample_3, sample_4,
             sample_fail_mask, requested_dir, drive_dir, zero_request, time_us,
      input  ready
   );
   modport sink (
      input  valid, sample_0, sample_1, sample_2, sample_3, sample_4,
             sample_fail_mask, requested_dir, drive_dir, zero_request, time_us,
      output ready
   );
endinterface

interface mwt_rsp_if #(
   parameter int ADC_BITS = 12
);
   logic                valid;
   logic                ready;
   logic [ADC_BITS-1:0] median_sample;
   logic [ADC_BITS-1:0] filtered_level;
   logic signed [31:0]  turn_thousandths;
   logic                dead_zone_flag;

   modport source (
      output valid, median_sample, filtered_level, turn_thousandths, dead_zone_flag,
      input  ready
   );
   modport sink (
      input  valid, median_sample, filtered_level, turn_thousandths, dead_zone_flag,
      output ready
   );
endinterface

interface mwt_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [31:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/mwt_lane.sv =====
`default_nettype none

module mwt_lane
   import mwt_pkg::*;
#(
   parameter int ADC_BITS = 12,
   parameter int LANE     = 0
) (
   input  wire logic [LANES-1:0][ADC_BITS-1:0] level_vec,
   output logic                                is_median
);

   logic [RANK_W-1:0] rank;

   // rank with ties broken by lane order, so exactly one lane sits in the middle
   always_comb begin
      logic below;
      rank = '0;
      for (int j = 0; j < LANES; j++) begin
         below = 1'b0;
         if (j != LANE) begin
            below = (level_vec[j] < level_vec[LANE]) ||
                    ((level_vec[j] == level_vec[LANE]) && (j < LANE));
         end
         rank = rank + RANK_W'(below);
      end
   end

   assign is_median = (rank == RANK_W'(MEDIAN_RANK));

endmodule

`default_nettype wire

// ===== rtl/mwt_track.sv =====
`default_nettype none

module mwt_track
   import mwt_pkg::*;
#(
   parameter int ADC_BITS = 12
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                accept,
   input  wire cfg_type                             cfg,
   input  wire logic [LANES-1:0][ADC_BITS-1:0]      level_vec,
   input  wire logic [LANES-1:0]                    lane_median,
   input  wire logic [DIR_W-1:0]                    requested_dir,
   input  wire logic [DIR_W-1:0]                    drive_dir,
   input  wire logic                                zero_request,
   input  wire logic [TIME_W-1:0]                   time_us,
   output logic      [ADC_BITS-1:0]                 last_raw,
   output logic      [ADC_BITS-1:0]                 raw,
   output logic      [ADC_BITS-1:0]                 filter_next,
   output logic      [TURN_W-1:0]                   turns_next,
   output logic                                     dead
);

   localparam int LW = (ADC_BITS > DEAD_W) ? ADC_BITS : DEAD_W;
   localparam int XW = LW + 1;
   localparam int SW = ADC_BITS + 2;

   logic [ADC_BITS-1:0] last_raw_ff, last_raw_in;
   logic [ADC_BITS-1:0] filter_ff, filter_in;
   logic [TURN_W-1:0]   acc_ff, acc_in;
   logic [TURN_W-1:0]   turns_ff, turns_in;
   logic [ADC_BITS-1:0] last_good_ff, last_good_in;
   logic [ADC_BITS-1:0] entry_ff, entry_in;
   logic                good_seen_ff, good_seen_in;
   logic                entry_known_ff, entry_known_in;
   logic                in_dead_ff, in_dead_in;
   logic [DIR_W-1:0]    motion_dir_ff, motion_dir_in;
   logic [TIME_W-1:0]   motion_time_ff, motion_time_in;

   logic [TIME_W-1:0]   elapsed;
   logic                hold;
   logic [DIR_W-1:0]    dir;
   logic                dir_fwd, dir_rev;
   logic [XW-1:0]       raw_x, entry_x, delta_x;
   logic                jump_up, jump_down, leaving;
   logic [SW-1:0]       filter_sum;
   logic [TURN_W-1:0]   acc_base;

   // merge: the one lane holding the middle rank drives the raw level
   always_comb begin
      raw = '0;
      for (int i = 0; i < LANES; i++) begin
         raw = raw | (lane_median[i] ? level_vec[i] : '0);
      end
   end

   assign motion_dir_in  = (drive_dir != DIR_NONE) ? drive_dir : motion_dir_ff;
   assign motion_time_in = (drive_dir != DIR_NONE) ? time_us : motion_time_ff;

   assign elapsed = time_us - motion_time_in;
   // time running backwards keeps the hold in force
   assign hold = (time_us < motion_time_in) ||
                 ((elapsed[TIME_W-1:HOLD_W] == '0) &&
                  (elapsed[HOLD_W-1:0] <= cfg.motion_hold_us));
   assign dir = (requested_dir != DIR_NONE) ? requested_dir :
                (hold ? motion_dir_in : DIR_NONE);
   assign dir_fwd = (dir == DIR_FORWARD);
   assign dir_rev = dir[DIR_W-1];

   assign filter_sum = {2'b00, filter_ff} + {1'b0, filter_ff, 1'b0} +
                       {2'b00, raw} + SW'(2);
   assign filter_in  = (filter_ff == '0) ? raw : filter_sum[SW-1:2];

   assign raw_x   = XW'(raw);
   assign entry_x = XW'(entry_ff);
   assign delta_x = XW'(cfg.wrap_min_delta);
   assign dead    = (raw_x <= XW'(cfg.dead_max));

   assign jump_up   = raw_x > (entry_x + delta_x);
   assign jump_down = entry_x > (raw_x + delta_x);
   assign leaving   = !dead && in_dead_ff && entry_known_ff;

   assign acc_base = zero_request ? '0 : acc_ff;

   always_comb begin
      acc_in = acc_base;
      if (leaving && dir_fwd && jump_up) begin
         acc_in = acc_base + TURN_SCALE;
      end else if (leaving && dir_rev && jump_down) begin
         acc_in = acc_base - TURN_SCALE;
      end
   end

   // turns are frozen inside the dead zone, only a zero request clears them
   assign turns_in = dead ? (zero_request ? '0 : turns_ff) : acc_in;

   assign entry_in       = (dead && !in_dead_ff && good_seen_ff) ? last_good_ff : entry_ff;
   assign entry_known_in = dead ? (entry_known_ff || (!in_dead_ff && good_seen_ff)) : 1'b0;
   assign in_dead_in     = dead;
   assign good_seen_in   = good_seen_ff || !dead;
   assign last_good_in   = dead ? last_good_ff : raw;
   assign last_raw_in    = raw;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_raw_ff    <= '0;
         filter_ff      <= '0;
         acc_ff         <= '0;
         turns_ff       <= '0;
         last_good_ff   <= '0;
         entry_ff       <= '0;
         good_seen_ff   <= 1'b0;
         entry_known_ff <= 1'b0;
         in_dead_ff     <= 1'b0;
         motion_dir_ff  <= DIR_NONE;
         motion_time_ff <= '0;
      end else if (accept) begin
         last_raw_ff    <= last_raw_in;
         filter_ff      <= filter_in;
         acc_ff         <= acc_in;
         turns_ff       <= turns_in;
         last_good_ff   <= last_good_in;
         entry_ff       <= entry_in;
         good_seen_ff   <= good_seen_in;
         entry_known_ff <= entry_known_in;
         in_dead_ff     <= in_dead_in;
         motion_dir_ff  <= motion_dir_in;
         motion_time_ff <= motion_time_in;
      end
   end

   assign last_raw    = last_raw_ff;
   assign filter_next = filter_in;
   assign turns_next  = turns_in;

   a_one_median: assert property (@(posedge clock) disable iff (reset)
      accept |-> $onehot(lane_median))
      else $error("median lanes not one-hot");

   a_entry_in_dead: assert property (@(posedge clock) disable iff (reset)
      entry_known_ff |-> in_dead_ff)
      else $error("entry level latched outside dead zone");

   a_zero_in_dead: assert property (@(posedge clock) disable iff (reset)
      (accept && zero_request && dead) |=> (turns_ff == '0))
      else $error("zero request in dead zone left turns set");

   a_good_seen: assert property (@(posedge clock) disable iff (reset)
      (accept && !dead) |=> (good_seen_ff && (last_good_ff == $past(raw))))
      else $error("last good level not captured");

endmodule

`default_nettype wire

// ===== rtl/multiturn_pot_wrap_tracker.sv =====
// Multiturn potentiometer wrap tracker. Each request carries five converter
// samples; failed ones take the previous raw level, five rank lanes pick the
// median, and one tracking stage runs the 3/4 filter, the dead-zone latch and
// the wrap counter. A request is taken every clock cycle and its response
// appears in the output register in the cycle after acceptance; the output
// register frees on the same edge it is read, so throughput is one request
// per cycle and only rsp backpressure stalls the input. The rate is set by the
// tracking stage, whose state feeds the next request's failed-sample
// substitution. Registers: 0 dead_max, 1 wrap_min_delta, 2 motion_hold_us;
// csr writes are always accepted and should be made while the block is idle.
`default_nettype none

module multiturn_pot_wrap_tracker
   import mwt_pkg::*;
#(
   parameter int ADC_BITS = 12
) (
   input wire logic clock,
   input wire logic reset,
   mwt_req_if.sink  req,
   mwt_rsp_if.source rsp,
   mwt_csr_if.sink  csr
);

   cfg_type cfg_ff, cfg_in;

   logic                          accept;
   logic [LANES-1:0][ADC_BITS-1:0] sample_vec;
   logic [LANES-1:0][ADC_BITS-1:0] level_vec;
   logic [LANES-1:0]              lane_median;
   logic [ADC_BITS-1:0]           last_raw;
   logic [ADC_BITS-1:0]           raw;
   logic [ADC_BITS-1:0]           filter_next;
   logic [TURN_W-1:0]             turns_next;
   logic                          dead;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [ADC_BITS-1:0] median_ff;
   logic [ADC_BITS-1:0] filtered_ff;
   logic [TURN_W-1:0]   turns_ff;
   logic                dead_flag_ff;

   // configuration registers
   assign csr.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr.valid) begin
         unique case (csr_index_type'(csr.index))
            CSR_DEAD_MAX:       cfg_in.dead_max       = csr.data[DEAD_W-1:0];
            CSR_WRAP_MIN_DELTA: cfg_in.wrap_min_delta = csr.data[DEAD_W-1:0];
            CSR_MOTION_HOLD_US: cfg_in.motion_hold_us = csr.data[HOLD_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dead_max       <= DEAD_MAX_RESET;
         cfg_ff.wrap_min_delta <= WRAP_MIN_DELTA_RESET;
         cfg_ff.motion_hold_us <= MOTION_HOLD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // request side
   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;

   assign sample_vec[0] = req.sample_0;
   assign sample_vec[1] = req.sample_1;
   assign sample_vec[2] = req.sample_2;
   assign sample_vec[3] = req.sample_3;
   assign sample_vec[4] = req.sample_4;

   for (genvar i = 0; i < LANES; i++) begin : g_lane
      // a failed sample stands in with the previous raw level
      assign level_vec[i] = req.sample_fail_mask[i] ? last_raw : sample_vec[i];

      mwt_lane #(
         .ADC_BITS (ADC_BITS),
         .LANE     (i)
      ) u_lane (
         .level_vec (level_vec),
         .is_median (lane_median[i])
      );
   end

   mwt_track #(
      .ADC_BITS (ADC_BITS)
   ) u_track (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .cfg           (cfg_ff),
      .level_vec     (level_vec),
      .lane_median   (lane_median),
      .requested_dir (req.requested_dir),
      .drive_dir     (req.drive_dir),
      .zero_request  (req.zero_request),
      .time_us       (req.time_us),
      .last_raw      (last_raw),
      .raw           (raw),
      .filter_next   (filter_next),
      .turns_next    (turns_next),
      .dead          (dead)
   );

   // response register
   assign rsp_valid_in = accept ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         median_ff    <= raw;
         filtered_ff  <= filter_next;
         turns_ff     <= turns_next;
         dead_flag_ff <= dead;
      end
   end

   assign rsp.valid            = rsp_valid_ff;
   assign rsp.median_sample    = median_ff;
   assign rsp.filtered_level   = filtered_ff;
   assign rsp.turn_thousandths = turns_ff;
   assign rsp.dead_zone_flag   = dead_flag_ff;

endmodule

`default_nettype wire
